### hw/rtl/imm_pkg.sv
// Package for the integer matrix multiply unit: sizes, codes, transaction structs.
// Used by every module under hw/rtl; depends on nothing.

package imm_pkg;

    localparam int MAX_DIM = 16;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 5;
    localparam int CIDX_W  = 1;
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] KIND_WR_A = 2'd0;
    localparam logic [1:0] KIND_WR_B = 2'd1;
    localparam logic [1:0] KIND_RD   = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [CIDX_W-1:0] CFG_DIMENSION = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_ROWS      = 1'b1;

    localparam logic [DIM_W-1:0] SIZE_RESET = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] product;
        logic                     index_error;
    } result_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic              err;
        logic [IDX_W-1:0]  k_last;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

### hw/rtl/imm_front.sv
// Front end: holds the size registers, accepts transactions and classifies them.
// Depends on imm_pkg; feeds imm_queue.

module imm_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  imm_pkg::item_t               item,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [imm_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]    cfg_data,
    input  imm_pkg::q_status_t           q_status,
    output logic                         push,
    output imm_pkg::q_entry_t            push_entry
);
    import imm_pkg::*;

    logic              valid_reg, valid_next;
    item_t             item_reg;
    logic [DIM_W-1:0]  dimension_reg, dimension_next;
    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic [DIM_W-1:0]  n_use, m_use;
    logic              accept;

    assign busy   = valid_reg && q_status.full;
    assign accept = start && !busy;
    assign push   = valid_reg && !q_status.full;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
            valid_next = 1'b0;
        if (accept && item.kind != KIND_NONE)
            valid_next = 1'b1;
    end

    always_comb
    begin
        dimension_next = dimension_reg;
        rows_next      = rows_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIMENSION: dimension_next = cfg_data;
                CFG_ROWS:      rows_next      = cfg_data;
                default:       dimension_next = dimension_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            dimension_reg <= SIZE_RESET;
            rows_reg      <= SIZE_RESET;
        end
        else
        begin
            valid_reg     <= valid_next;
            dimension_reg <= dimension_next;
            rows_reg      <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    assign n_use = clamp_size(dimension_reg);
    assign m_use = clamp_size(rows_reg);

    always_comb
    begin
        push_entry.kind   = item_reg.kind;
        push_entry.row    = item_reg.row;
        push_entry.col    = item_reg.col;
        push_entry.value  = item_reg.value;
        push_entry.err    = (DIM_W'(item_reg.row) >= m_use) || (DIM_W'(item_reg.col) >= n_use);
        push_entry.k_last = IDX_W'(n_use - DIM_W'(1));
    end

endmodule

### hw/rtl/imm_queue.sv
// Short FIFO of classified transactions between front and back end.
// Depends on imm_pkg.

module imm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  imm_pkg::q_entry_t   push_entry,
    input  logic                pop,
    output imm_pkg::q_entry_t   head,
    output imm_pkg::q_status_t  status
);
    import imm_pkg::*;

    q_entry_t            entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### hw/rtl/imm_back.sv
// Back end: owns the A and B memories, performs writes and serial dot products.
// Depends on imm_pkg; drains imm_queue.

module imm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  imm_pkg::q_entry_t   head,
    input  imm_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                done,
    output imm_pkg::result_t    result
);
    import imm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [DATA_W-1:0]  a_mem [DEPTH];
    logic [DATA_W-1:0]  b_mem [DEPTH];
    logic [DATA_W-1:0]  a_rdata_reg, b_rdata_reg;
    logic [DATA_W-1:0]  mul_reg, acc_reg, acc_next;
    logic [IDX_W-1:0]   row_reg, col_reg, k_reg, k_next, last_reg;
    logic               rd_v_reg, rd_last_reg, mul_v_reg, mul_last_reg;
    logic               issue, issue_last, start_rd;
    logic               wr_a, wr_b;
    logic [ADDR_W-1:0]  wr_addr, a_addr, b_addr;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    assign pop        = (state_reg == ST_IDLE) && !q_status.empty;
    assign wr_a       = pop && head.kind == KIND_WR_A;
    assign wr_b       = pop && head.kind == KIND_WR_B;
    assign start_rd   = pop && head.kind == KIND_RD && !head.err;
    assign wr_addr    = {head.row, head.col};
    assign issue      = (state_reg == ST_RUN);
    assign issue_last = issue && (k_reg == last_reg);
    assign a_addr     = {row_reg, k_reg};
    assign b_addr     = {k_reg, col_reg};

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (mul_v_reg)
            acc_next = acc_reg + mul_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && head.kind == KIND_RD)
                begin
                    if (head.err)
                    begin
                        done_next               = 1'b1;
                        result_next.product     = '0;
                        result_next.index_error = 1'b1;
                    end
                    else
                    begin
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                k_next = k_reg + IDX_W'(1);
                if (issue_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mul_v_reg && mul_last_reg)
                begin
                    done_next               = 1'b1;
                    result_next.product     = acc_next;
                    result_next.index_error = 1'b0;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_v_reg     <= 1'b0;
            rd_last_reg  <= 1'b0;
            mul_v_reg    <= 1'b0;
            mul_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_v_reg     <= issue;
            rd_last_reg  <= issue_last;
            mul_v_reg    <= rd_v_reg;
            mul_last_reg <= rd_last_reg;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_rd)
        begin
            row_reg  <= head.row;
            col_reg  <= head.col;
            last_reg <= head.k_last;
        end
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        mul_reg    <= a_rdata_reg * b_rdata_reg;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[wr_addr] <= head.value;
        if (issue)
            a_rdata_reg <= a_mem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
            b_mem[wr_addr] <= head.value;
        if (issue)
            b_rdata_reg <= b_mem[b_addr];
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/integer_matrix_multiply_unit.sv
// Top level of the integer matrix multiply unit: front end, queue, back end.
// Depends on imm_pkg, imm_front, imm_queue and imm_back.
//
//   channel   handshake         payload
//   input     start / busy      item   (kind, row, col, value)
//   result    done (strobe)     result (product, index_error)
//   config    cfg_we            cfg_index, cfg_data
//
// A write is done as it is popped. A read is popped, then issues one A and B
// memory read per k; each product passes the read and multiply registers, and
// no item is popped until its done strobe. An out-of-range read answers with
// index_error and no dot product. busy rises only when the four-entry queue and
// the front stage are full; the receiver cannot stall results.
// Reset clears control only; the memories are undefined until written.

module integer_matrix_multiply_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  imm_pkg::item_t              item,
    output logic                        busy,
    output logic                        done,
    output imm_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [imm_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]   cfg_data
);
    import imm_pkg::*;

    logic       push, pop;
    q_entry_t   push_entry, head;
    q_status_t  q_status;

    imm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    imm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    imm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

endmodule
